@@ src/nrmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared types, character codes and helpers for the RMC sentence parser.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  localparam int LAT_W = 34;
  localparam int LON_W = 37;
  localparam int LAT_MAG_W = 33;
  localparam int LON_MAG_W = 36;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;

  // field numbers
  localparam logic [3:0] FLD_HDR    = 4'd0;
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_DATE   = 4'd9;
  localparam logic [3:0] FLD_LAST   = 4'd14;
  localparam logic [3:0] FLD_NONE   = 4'd15;

  // flag bits
  localparam int FL_TIME   = 0;
  localparam int FL_STSEEN = 1;
  localparam int FL_STA    = 2;
  localparam int FL_LAT    = 3;
  localparam int FL_NS     = 4;
  localparam int FL_LON    = 5;
  localparam int FL_EW     = 6;
  localparam int FL_DATE   = 7;

  localparam logic [6:0] LAT_DEG = 7'd2;
  localparam logic [6:0] LON_DEG = 7'd3;

  typedef struct packed {
    logic        ok;
    logic [15:0] ip;    // degrees * 60 + minutes
    logic [19:0] frac;  // millionths of a minute
  } coord_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_digit(c)) r = {1'b1, 4'(c - CH_0)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic logic [19:0] frac_weight(input logic [2:0] i);
    logic [19:0] w;
    unique case (i)
      3'd0:    w = 20'd1;
      3'd1:    w = 20'd10;
      3'd2:    w = 20'd100;
      3'd3:    w = 20'd1000;
      3'd4:    w = 20'd10000;
      3'd5:    w = 20'd100000;
      default: w = 20'd0;
    endcase
    return w;
  endfunction

  function automatic coord_t coord_step(input logic [6:0] deg, input coord_t cur,
                                        input logic [7:0] c, input logic [6:0] k);
    coord_t     nxt;
    logic [3:0] d;
    nxt = cur;
    d   = 4'(c - CH_0);
    if (cur.ok) begin
      if (k == 7'(deg + 7'd2)) begin
        if (c != CH_DOT) nxt.ok = 1'b0;
      end else if (!is_digit(c)) begin
        nxt.ok = 1'b0;
      end else if (k == deg) begin
        nxt.ip = 16'(cur.ip * 16'd6 + 16'(d));
      end else if (k < deg) begin
        nxt.ip = 16'(cur.ip * 16'd10 + 16'(d));
      end else if (k == 7'(deg + 7'd1)) begin
        nxt.ip = 16'(cur.ip * 16'd10 + 16'(d));
      end else if (k < 7'(deg + 7'd9)) begin
        nxt.frac = 20'(cur.frac + 20'(d) * frac_weight(3'(deg + 7'd8 - k)));
      end
    end
    return nxt;
  endfunction

endpackage

@@ src/nrmc_byte_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_byte_if
// Received character channel, valid/ready.
// ----------------------------------------------------------------------------
interface nrmc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ src/nrmc_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_res_if
// Parsed sentence channel, valid/ready.
// ----------------------------------------------------------------------------
interface nrmc_res_if
  import nrmc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    checksum_ok;
  logic                    time_valid;
  logic                    position_valid;
  logic [6:0]              hours;
  logic [6:0]              minutes;
  logic [6:0]              seconds;
  logic [6:0]              day;
  logic [6:0]              month;
  logic [6:0]              year;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;
  logic                    sentence_done;

  modport source (output valid, output checksum_ok, output time_valid,
                  output position_valid, output hours, output minutes, output seconds,
                  output day, output month, output year, output latitude,
                  output longitude, output sentence_done, input ready);
  modport sink (input valid, input checksum_ok, input time_valid,
                input position_valid, input hours, input minutes, input seconds,
                input day, input month, input year, input latitude,
                input longitude, input sentence_done, output ready);
endinterface

@@ src/nmea_rmc_sentence_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser
// Parses RMC sentences byte by byte into time, date and position.
//
//   channel  dir  payload
//   in_i     in   rx_byte
//   res_o    out  flags, time, date, latitude, longitude, sentence_done
//
// One byte per cycle while in_i.ready is high; a terminator byte loads the result
// register in the same cycle it is taken, so the item appears in the cycle after.
// Reset clears the parser control state and the result valid, not the data registers.
// A held result stalls input only while res_o.ready is low.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser
  import nrmc_pkg::*;
#(
  parameter int MAX_SENTENCE = 96
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nrmc_byte_if.sink    in_i,
  nrmc_res_if.source   res_o
);

  logic                 in_sent_q, in_sent_d;
  logic [6:0]           cnt_q, cnt_d;
  logic [7:0]           xor_q, xor_d;
  logic [7:0]           r0_q, r0_d, r1_q, r1_d, r2_q, r2_d;
  logic [3:0]           fidx_q, fidx_d;
  logic [6:0]           fcnt_q, fcnt_d;
  logic                 hdr_q, hdr_d;
  logic [5:0][3:0]      tdig_q, tdig_d, ddig_q, ddig_d;
  logic [15:0]          lat_ip_q, lat_ip_d, lon_ip_q, lon_ip_d;
  logic [19:0]          lat_fr_q, lat_fr_d, lon_fr_q, lon_fr_d;
  logic [LAT_MAG_W-1:0] lat_mag_q, lat_mag_d;
  logic [LON_MAG_W-1:0] lon_mag_q, lon_mag_d;
  logic [7:0]           fl_q, fl_d;

  logic       accept, term, res_load;
  logic [7:0] c;
  coord_t     cs_step;
  logic [4:0] hx_hi, hx_lo;
  logic       cs_ok, good, tv, pv;

  assign c        = in_i.rx_byte;
  assign in_i.ready = !res_o.valid || res_o.ready;
  assign accept   = in_i.valid && in_i.ready;
  assign term     = (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);

  always_comb begin
    in_sent_d = in_sent_q; cnt_d = cnt_q; xor_d = xor_q;
    r0_d = r0_q; r1_d = r1_q; r2_d = r2_q;
    fidx_d = fidx_q; fcnt_d = fcnt_q; hdr_d = hdr_q;
    tdig_d = tdig_q; ddig_d = ddig_q;
    lat_ip_d = lat_ip_q; lat_fr_d = lat_fr_q; lon_ip_d = lon_ip_q; lon_fr_d = lon_fr_q;
    lat_mag_d = lat_mag_q; lon_mag_d = lon_mag_q; fl_d = fl_q;
    res_load = 1'b0;
    cs_step = '0;

    if (accept && !in_sent_q) begin
      if (c == CH_DOLLAR) begin
        in_sent_d = 1'b1; cnt_d = 7'd1; xor_d = '0;
        r0_d = '0; r1_d = '0; r2_d = '0;
        fidx_d = FLD_HDR; fcnt_d = '0; hdr_d = 1'b1;
        tdig_d = '0; ddig_d = '0;
        lat_ip_d = '0; lat_fr_d = '0; lon_ip_d = '0; lon_fr_d = '0;
        lat_mag_d = '0; lon_mag_d = '0; fl_d = '0;
      end
    end else if (accept) begin
      // close the current field on a separator or terminator
      if (fidx_q != FLD_NONE && (term || c == CH_COMMA || c == CH_STAR)) begin
        unique case (fidx_q)
          FLD_HDR:  if (fcnt_q < 7'd5) hdr_d = 1'b0;
          FLD_TIME: if (fcnt_q < 7'd6) fl_d[FL_TIME] = 1'b0;
          FLD_LAT: begin
            if (fcnt_q < 7'(LAT_DEG + 7'd2)) fl_d[FL_LAT] = 1'b0;
            lat_mag_d = LAT_MAG_W'(36'(lat_ip_q) * 36'd1000000 + 36'(lat_fr_q));
          end
          FLD_LON: begin
            if (fcnt_q < 7'(LON_DEG + 7'd2)) fl_d[FL_LON] = 1'b0;
            lon_mag_d = LON_MAG_W'(36'(lon_ip_q) * 36'd1000000 + 36'(lon_fr_q));
          end
          FLD_DATE: if (fcnt_q < 7'd6) fl_d[FL_DATE] = 1'b0;
          default: ;
        endcase
      end

      if (term) begin
        res_load  = 1'b1;
        in_sent_d = 1'b0;
      end else begin
        xor_d = xor_q ^ c;
        r2_d = r1_q; r1_d = r0_q; r0_d = c;
        if (fidx_q != FLD_NONE) begin
          if (c == CH_COMMA) begin
            if (fidx_q < FLD_LAST) fidx_d = fidx_q + 4'd1;
            fcnt_d = '0;
            unique case (fidx_d)
              FLD_TIME: fl_d[FL_TIME] = 1'b1;
              FLD_LAT:  fl_d[FL_LAT]  = 1'b1;
              FLD_LON:  fl_d[FL_LON]  = 1'b1;
              FLD_DATE: fl_d[FL_DATE] = 1'b1;
              default: ;
            endcase
          end else if (c == CH_STAR) begin
            fidx_d = FLD_NONE;
          end else if (fidx_q == FLD_HDR || c != CH_SPACE) begin
            unique case (fidx_q)
              FLD_HDR: begin
                if ((fcnt_q == 7'd0 && c != CH_G) || (fcnt_q == 7'd2 && c != CH_R) ||
                    (fcnt_q == 7'd3 && c != CH_M) || (fcnt_q == 7'd4 && c != CH_C))
                  hdr_d = 1'b0;
              end
              FLD_TIME: begin
                if (fcnt_q < 7'd6 && fl_q[FL_TIME]) begin
                  if (is_digit(c)) tdig_d[fcnt_q[2:0]] = 4'(c - CH_0);
                  else fl_d[FL_TIME] = 1'b0;
                end
              end
              FLD_STATUS: begin
                if (fcnt_q == 7'd0) begin
                  fl_d[FL_STSEEN] = 1'b1;
                  if (c == CH_A) fl_d[FL_STA] = 1'b1;
                end
              end
              FLD_LAT: begin
                cs_step = coord_step(LAT_DEG, '{fl_q[FL_LAT], lat_ip_q, lat_fr_q}, c, fcnt_q);
                fl_d[FL_LAT] = cs_step.ok; lat_ip_d = cs_step.ip; lat_fr_d = cs_step.frac;
              end
              FLD_NS: begin
                if (fcnt_q == 7'd0) begin
                  fl_d[FL_NS]  = (c == CH_N || c == CH_S) && fl_q[FL_LAT];
                  fl_d[FL_LAT] = (c == CH_S);
                end
              end
              FLD_LON: begin
                cs_step = coord_step(LON_DEG, '{fl_q[FL_LON], lon_ip_q, lon_fr_q}, c, fcnt_q);
                fl_d[FL_LON] = cs_step.ok; lon_ip_d = cs_step.ip; lon_fr_d = cs_step.frac;
              end
              FLD_EW: begin
                if (fcnt_q == 7'd0) begin
                  fl_d[FL_EW]  = (c == CH_E || c == CH_W) && fl_q[FL_LON];
                  fl_d[FL_LON] = (c == CH_W);
                end
              end
              FLD_DATE: begin
                if (fcnt_q < 7'd6 && fl_q[FL_DATE]) begin
                  if (is_digit(c)) ddig_d[fcnt_q[2:0]] = 4'(c - CH_0);
                  else fl_d[FL_DATE] = 1'b0;
                end
              end
              default: ;
            endcase
            if (fcnt_q != 7'd127) fcnt_d = fcnt_q + 7'd1;
          end
        end
        cnt_d = cnt_q + 7'd1;
        // drop an over-long sentence
        if (cnt_d >= 7'(MAX_SENTENCE - 1)) in_sent_d = 1'b0;
      end
    end
  end

  assign hx_hi = hex_val(r1_q);
  assign hx_lo = hex_val(r0_q);
  assign cs_ok = (cnt_q >= 7'd4) && (r2_q == CH_STAR) && hx_hi[4] && hx_lo[4] &&
                 ((xor_q ^ r0_q ^ r1_q ^ r2_q) == {hx_hi[3:0], hx_lo[3:0]});
  assign good  = cs_ok && hdr_d && fl_d[FL_STSEEN];
  assign tv    = good && fl_d[FL_TIME] && fl_d[FL_DATE];
  assign pv    = good && fl_d[FL_STA] && fl_d[FL_NS] && fl_d[FL_EW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q <= 1'b0; cnt_q <= '0; xor_q <= '0;
      r0_q <= '0; r1_q <= '0; r2_q <= '0;
      fidx_q <= '0; fcnt_q <= '0; hdr_q <= 1'b0; fl_q <= '0;
      res_o.valid <= 1'b0;
    end else begin
      in_sent_q <= in_sent_d; cnt_q <= cnt_d; xor_q <= xor_d;
      r0_q <= r0_d; r1_q <= r1_d; r2_q <= r2_d;
      fidx_q <= fidx_d; fcnt_q <= fcnt_d; hdr_q <= hdr_d; fl_q <= fl_d;
      if (res_load) res_o.valid <= 1'b1;
      else if (res_o.ready) res_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    tdig_q <= tdig_d; ddig_q <= ddig_d;
    lat_ip_q <= lat_ip_d; lat_fr_q <= lat_fr_d;
    lon_ip_q <= lon_ip_d; lon_fr_q <= lon_fr_d;
    lat_mag_q <= lat_mag_d; lon_mag_q <= lon_mag_d;
    if (res_load) begin
      res_o.checksum_ok    <= cs_ok;
      res_o.time_valid     <= tv;
      res_o.position_valid <= pv;
      res_o.hours   <= tv ? 7'(tdig_q[0] * 7'd10 + 7'(tdig_q[1])) : 7'd0;
      res_o.minutes <= tv ? 7'(tdig_q[2] * 7'd10 + 7'(tdig_q[3])) : 7'd0;
      res_o.seconds <= tv ? 7'(tdig_q[4] * 7'd10 + 7'(tdig_q[5])) : 7'd0;
      res_o.day     <= tv ? 7'(ddig_q[0] * 7'd10 + 7'(ddig_q[1])) : 7'd0;
      res_o.month   <= tv ? 7'(ddig_q[2] * 7'd10 + 7'(ddig_q[3])) : 7'd0;
      res_o.year    <= tv ? 7'(ddig_q[4] * 7'd10 + 7'(ddig_q[5])) : 7'd0;
      // sign from the direction letter
      res_o.latitude  <= !pv ? '0 : fl_q[FL_LAT] ? -LAT_W'(lat_mag_q) : LAT_W'(lat_mag_q);
      res_o.longitude <= !pv ? '0 : fl_q[FL_LON] ? -LON_W'(lon_mag_q) : LON_W'(lon_mag_q);
      res_o.sentence_done <= 1'b1;
    end
  end

  a_flags_need_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && (tv || pv) |=> res_o.checksum_ok)
    else $error("valid flags without checksum");
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && !pv |=> res_o.latitude == '0 && res_o.longitude == '0)
    else $error("position not cleared");
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> res_o.valid && !res_o.ready)
    else $error("input stalled without a pending result");
  a_term_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> !in_sent_q && res_o.valid)
    else $error("sentence not closed on result");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RMC sentence parser: directed sentences with
// typed flags, then random well-formed, damaged and noisy sentences, each
// result checked field by field against a cycle-free byte-level predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import nrmc_pkg::*;

  localparam int MAX_SENT  = 96;
  localparam int CYC_LIMIT = 400000;
  localparam int HOLD_CYC  = 400;

  // checksum suffix styles
  localparam int CK_NONE  = 0;
  localparam int CK_UPPER = 1;
  localparam int CK_LOWER = 2;
  localparam int CK_BAD   = 3;

  typedef struct {
    logic [7:0] b;
    bit         pin;
    bit         cs, tv, pv;
  } tx_byte_t;

  typedef struct {
    logic                    cs, tv, pv;
    logic [6:0]              hh, mm, ss, dd, mo, yy;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } fix_t;

  typedef struct {
    string      body;
    int         ck;
    logic [7:0] term;
    bit         pin;
    bit         cs, tv, pv;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  nrmc_byte_if in_if ();
  nrmc_res_if  res_if ();

  nmea_rmc_sentence_parser #(.MAX_SENTENCE(MAX_SENT)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .res_o (res_if.source)
  );

  always #6 clk_i = ~clk_i;

  tx_byte_t byte_q[$];
  // pin data rides with the bytes in flight, in order
  tx_byte_t flight_q[$];
  fix_t     fix_q[$];
  int       errors = 0;
  int       cycles = 0;
  int       taken = 0;
  bit       quiet = 1'b0;
  bit       hold = 1'b0;

  // ---------------- predictor state ----------------
  logic        p_open;
  logic [6:0]  p_cnt;
  logic [7:0]  p_xor;
  logic [7:0]  p_rc[3];
  logic [3:0]  p_fld;
  logic [6:0]  p_fcc;
  logic        p_hdr;
  logic [31:0] p_time, p_date;
  logic [63:0] p_lat, p_lon;
  logic [7:0]  p_fl;

  function automatic bit dig(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic int hexv(logic [7:0] c);
    if (dig(c)) return c - CH_0;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  task automatic clear_parse();
    p_cnt = '0; p_xor = '0; p_rc = '{default: 8'h00};
    p_fld = FLD_HDR; p_fcc = '0; p_hdr = 1'b0;
    p_time = '0; p_date = '0; p_lat = '0; p_lon = '0; p_fl = '0;
  endtask

  task automatic coord_in(inout logic [63:0] acc, input int deg, input int bi,
                          input logic [7:0] c, input int k);
    if (!p_fl[bi]) return;
    if (k == deg + 2) begin
      if (c != CH_DOT) p_fl[bi] = 1'b0;
      return;
    end
    if (!dig(c)) begin
      p_fl[bi] = 1'b0;
      return;
    end
    if (k == deg) acc = acc * 6 + (c - CH_0);
    else if (k < deg + 9) acc = acc * 10 + (c - CH_0);
  endtask

  task automatic coord_end(inout logic [63:0] acc, input int deg, input int bi);
    int k;
    int n;
    k = p_fcc;
    n = 0;
    if (!p_fl[bi]) return;
    if (k < deg + 2) begin
      p_fl[bi] = 1'b0;
      return;
    end
    if (k > deg + 3) n = k - deg - 3;
    if (n > 6) n = 6;
    repeat (6 - n) acc = acc * 10;
  endtask

  task automatic six_in(inout logic [31:0] v, input int bi, input logic [7:0] c,
                        input int k);
    if (k >= 6 || !p_fl[bi]) return;
    if (dig(c)) v = v * 10 + (c - CH_0);
    else p_fl[bi] = 1'b0;
  endtask

  task automatic close_fld();
    case (p_fld)
      FLD_HDR:  if (p_fcc < 5) p_hdr = 1'b0;
      FLD_TIME: if (p_fcc < 6) p_fl[FL_TIME] = 1'b0;
      FLD_LAT:  coord_end(p_lat, 2, FL_LAT);
      FLD_LON:  coord_end(p_lon, 3, FL_LON);
      FLD_DATE: if (p_fcc < 6) p_fl[FL_DATE] = 1'b0;
      default: ;
    endcase
  endtask

  task automatic open_fld();
    p_fcc = '0;
    case (p_fld)
      FLD_TIME: p_fl[FL_TIME] = 1'b1;
      FLD_LAT:  p_fl[FL_LAT] = 1'b1;
      FLD_LON:  p_fl[FL_LON] = 1'b1;
      FLD_DATE: p_fl[FL_DATE] = 1'b1;
      default: ;
    endcase
  endtask

  task automatic dir_in(logic [7:0] c, logic [7:0] pos, logic [7:0] neg, int vb, int ob);
    bit ok;
    ok = (c == pos || c == neg) && p_fl[vb];
    p_fl[vb] = 1'b0;
    p_fl[ob] = ok;
    if (c == neg) p_fl[vb] = 1'b1;
  endtask

  task automatic data_char(logic [7:0] c);
    int k;
    k = p_fcc;
    if (p_fld == FLD_HDR) begin
      if ((k == 0 && c != CH_G) || (k == 2 && c != CH_R) ||
          (k == 3 && c != CH_M) || (k == 4 && c != CH_C)) p_hdr = 1'b0;
    end else begin
      if (c == CH_SPACE) return;
      case (p_fld)
        FLD_TIME: six_in(p_time, FL_TIME, c, k);
        FLD_STATUS: if (k == 0) begin
          p_fl[FL_STSEEN] = 1'b1;
          if (c == CH_A) p_fl[FL_STA] = 1'b1;
        end
        FLD_LAT:  coord_in(p_lat, 2, FL_LAT, c, k);
        FLD_NS:   if (k == 0) dir_in(c, CH_N, CH_S, FL_LAT, FL_NS);
        FLD_LON:  coord_in(p_lon, 3, FL_LON, c, k);
        FLD_EW:   if (k == 0) dir_in(c, CH_E, CH_W, FL_LON, FL_EW);
        FLD_DATE: six_in(p_date, FL_DATE, c, k);
        default: ;
      endcase
    end
    if (p_fcc < 127) p_fcc++;
  endtask

  // advance the parser model by one accepted byte; queue a fix at a terminator
  task automatic parse_byte(tx_byte_t t);
    logic [7:0]  c;
    fix_t        f;
    int          hi, lo;
    bit          good;
    logic [63:0] la, lg;
    c = t.b;
    if (!p_open) begin
      if (c == CH_DOLLAR) begin
        clear_parse();
        p_open = 1'b1; p_cnt = 7'd1; p_hdr = 1'b1;
      end
      return;
    end
    if (c == CH_CR || c == CH_LF || c == CH_NUL) begin
      hi = hexv(p_rc[1]);
      lo = hexv(p_rc[0]);
      if (p_fld != FLD_NONE) close_fld();
      f = '{default: '0};
      if (p_cnt >= 4 && p_rc[2] == CH_STAR && hi >= 0 && lo >= 0)
        f.cs = (p_xor ^ p_rc[0] ^ p_rc[1] ^ p_rc[2]) == 8'(hi * 16 + lo);
      good = f.cs && p_hdr && p_fl[FL_STSEEN];
      f.tv = good && p_fl[FL_TIME] && p_fl[FL_DATE];
      f.pv = good && p_fl[FL_STA] && p_fl[FL_NS] && p_fl[FL_EW];
      if (f.tv) begin
        f.hh = 7'(p_time / 10000 % 100); f.mm = 7'(p_time / 100 % 100);
        f.ss = 7'(p_time % 100);
        f.dd = 7'(p_date / 10000 % 100); f.mo = 7'(p_date / 100 % 100);
        f.yy = 7'(p_date % 100);
      end
      if (f.pv) begin
        la = p_fl[FL_LAT] ? -p_lat : p_lat;
        lg = p_fl[FL_LON] ? -p_lon : p_lon;
        f.lat = la[LAT_W-1:0];
        f.lon = lg[LON_W-1:0];
      end
      if (t.pin) begin
        f.cs = t.cs; f.tv = t.tv; f.pv = t.pv;
      end
      fix_q.push_back(f);
      p_open = 1'b0;
      return;
    end
    p_xor ^= c;
    p_rc[2] = p_rc[1]; p_rc[1] = p_rc[0]; p_rc[0] = c;
    if (p_fld != FLD_NONE) begin
      if (c == CH_COMMA) begin
        close_fld();
        if (p_fld < FLD_LAST) p_fld++;
        open_fld();
      end else if (c == CH_STAR) begin
        close_fld();
        p_fld = FLD_NONE;
      end else begin
        data_char(c);
      end
    end
    p_cnt++;
    if (p_cnt >= MAX_SENT - 1) p_open = 1'b0;
  endtask

  // ---------------- stimulus building ----------------
  task automatic push_sentence(string body, int ck, logic [7:0] term, bit pin,
                               bit cs, bit tv, bit pv);
    logic [7:0] x;
    string      s;
    tx_byte_t   t;
    x = 8'h00;
    for (int i = 1; i < body.len(); i++) x ^= body[i];
    case (ck)
      CK_UPPER: s = $sformatf("%s*%02X", body, x);
      CK_LOWER: s = $sformatf("%s*%02x", body, x);
      CK_BAD:   s = $sformatf("%s*%02X", body, x ^ 8'h01);
      default:  s = body;
    endcase
    for (int i = 0; i < s.len(); i++) begin
      t = '{b: s[i], pin: 1'b0, cs: 1'b0, tv: 1'b0, pv: 1'b0};
      byte_q.push_back(t);
    end
    t = '{b: term, pin: pin, cs: cs, tv: tv, pv: pv};
    byte_q.push_back(t);
  endtask

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
    return s;
  endfunction

  function automatic string pick(string a, string b, string c, int pa, int pb);
    int r;
    r = $urandom_range(0, 99);
    if (r < pa) return a;
    if (r < pa + pb) return b;
    return c;
  endfunction

  function automatic string coord_txt(int deg);
    string s;
    s = digits(deg + 2);
    if ($urandom_range(0, 3) != 0) s = {s, ".", digits($urandom_range(0, 8))};
    if ($urandom_range(0, 9) == 0) s = digits($urandom_range(0, deg + 1));
    return s;
  endfunction

  function automatic string rand_body();
    string s;
    string f[$];
    int    p;
    s = $sformatf("$G%cRMC", 8'($urandom_range(65, 90)));
    if ($urandom_range(0, 9) == 0) s = $sformatf("$%s", digits(5));
    f.push_back(pick(digits(6), {digits(6), ".", digits(2)}, digits(4), 50, 40));
    f.push_back(pick("A", "V", "", 75, 15));
    f.push_back(coord_txt(2));
    f.push_back(pick("N", "S", "X", 45, 45));
    f.push_back(coord_txt(3));
    f.push_back(pick("E", "W", "", 45, 45));
    f.push_back(digits(3));
    f.push_back(digits(3));
    f.push_back(pick(digits(6), "", digits(5), 85, 8));
    repeat ($urandom_range(0, 3)) f.push_back(digits($urandom_range(0, 3)));
    foreach (f[i]) begin
      if ($urandom_range(0, 14) == 0) f[i] = {" ", f[i]};
      s = {s, ",", f[i]};
    end
    // damage one character now and then
    if ($urandom_range(0, 9) == 0) begin
      p = $urandom_range(1, s.len() - 1);
      s[p] = 8'($urandom_range(1, 255));
    end
    return s;
  endfunction

  function automatic logic [7:0] rand_term();
    int r;
    r = $urandom_range(0, 2);
    return r == 0 ? CH_CR : (r == 1 ? CH_LF : CH_NUL);
  endfunction

  task automatic push_noise(int n);
    tx_byte_t t;
    repeat (n) begin
      t = '{b: 8'($urandom_range(0, 255)), pin: 1'b0, cs: 1'b0, tv: 1'b0, pv: 1'b0};
      byte_q.push_back(t);
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_if.valid || fix_q.size() != 0) @(posedge clk_i);
  endtask

  row_t dir_rows[] = '{
    '{"$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W",
      CK_UPPER, CH_CR, 1, 1, 1, 1},
    '{"$GNRMC,235959.99,A,9959.999999,S,17959.999999,W,,,311299,,",
      CK_LOWER, CH_LF, 1, 1, 1, 1},
    '{"$GPRMC,000000,A,0000.000000,N,00000.000000,E,,,000000",
      CK_UPPER, CH_NUL, 1, 1, 1, 1},
    '{"$GPRMC,999999,A,9999.9999999999,S,99999.9999999999,W,,,999999",
      CK_UPPER, CH_CR, 0, 0, 0, 0},
    '{"$GPRMC,123519,V,4807.038,N,01131.000,E,,,230394", CK_UPPER, CH_CR, 1, 1, 1, 0},
    '{"$GPRMC,123519,A,4807.038,N,01131.000,E,,,", CK_UPPER, CH_CR, 1, 1, 0, 1},
    '{"$GPRMC,123519,A,4807.038,N,01131.000,E,,,230394", CK_BAD, CH_CR, 1, 0, 0, 0},
    '{"$GPRMC,123519,A,4807.038,N,01131.000,E,,,230394", CK_NONE, CH_CR, 1, 0, 0, 0},
    '{"$GPGGA,123519,A,4807.038,N,01131.000,E,,,230394", CK_UPPER, CH_CR, 1, 1, 0, 0},
    '{"$GPRMC,123519,,4807.038,N,01131.000,E,,,230394", CK_UPPER, CH_CR, 1, 1, 0, 0},
    '{"$GPRMC, 12 3519 , A ,48 07.038, S ,011 31.0 , W ,,, 230394", CK_LOWER, CH_CR,
      0, 0, 0, 0},
    '{"$GPRMC,123519,A,48x7.038,N,0113,E,,,230394", CK_UPPER, CH_CR, 1, 1, 1, 0},
    '{"$GPRMC,123519,A,4807.038,Q,01131.000,EW,,,2303", CK_UPPER, CH_CR, 1, 1, 0, 0},
    '{"$GPRMC,12$519,A,4807$038,N,01131.000,E,,,230394", CK_UPPER, CH_CR, 0, 0, 0, 0},
    '{"$GPRMC,123519,A,4807,N,01131,E,1,2,230394,3,4,5,6,7,8,9,10", CK_UPPER, CH_CR,
      0, 0, 0, 0},
    '{"$GPRMC,123519,A,480", CK_UPPER, CH_CR, 0, 0, 0, 0},
    '{"$", CK_NONE, CH_CR, 1, 0, 0, 0},
    '{"$", CK_UPPER, CH_LF, 0, 0, 0, 0},
    '{"$G*", CK_NONE, CH_NUL, 1, 0, 0, 0},
    '{{"$GPRMC,", {85{"1"}}}, CK_UPPER, CH_CR, 0, 0, 0, 0},
    '{{"$GPRMC,", {80{"2"}}}, CK_UPPER, CH_CR, 0, 0, 0, 0}
  };

  // ---------------- sender ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.rx_byte <= 8'h00;
    end else if (!in_if.valid || in_if.ready) begin
      if (byte_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 21)) begin
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= byte_q[0].b;
        flight_q.push_back(byte_q[0]);
        byte_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_if.ready <= 1'b0;
    else res_if.ready <= !hold && (quiet || $urandom_range(0, 99) >= 21);
  end

  always @(posedge clk_i) begin
    fix_t f;
    cycles <= cycles + 1;
    if (rst_ni && in_if.valid && in_if.ready) begin
      parse_byte(flight_q.pop_front());
      taken <= taken + 1;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (fix_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        f = fix_q.pop_front();
        if (res_if.checksum_ok !== f.cs || res_if.time_valid !== f.tv ||
            res_if.position_valid !== f.pv || res_if.hours !== f.hh ||
            res_if.minutes !== f.mm || res_if.seconds !== f.ss ||
            res_if.day !== f.dd || res_if.month !== f.mo || res_if.year !== f.yy ||
            res_if.latitude !== f.lat || res_if.longitude !== f.lon ||
            res_if.sentence_done !== 1'b1) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp cs%b tv%b pv%b %0d:%0d:%0d %0d/%0d/%0d %0d %0d",
                     f.cs, f.tv, f.pv, f.hh, f.mm, f.ss, f.dd, f.mo, f.yy, f.lat, f.lon);
            $display("          got cs%b tv%b pv%b %0d:%0d:%0d %0d/%0d/%0d %0d %0d done%b",
                     res_if.checksum_ok, res_if.time_valid, res_if.position_valid,
                     res_if.hours, res_if.minutes, res_if.seconds, res_if.day,
                     res_if.month, res_if.year, res_if.latitude, res_if.longitude,
                     res_if.sentence_done);
          end
        end
      end
    end
    if (cycles >= CYC_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- pressure: long receiver hold-off ----------------
  initial begin
    wait (taken > 900);
    hold = 1'b1;
    repeat (HOLD_CYC) @(posedge clk_i);
    hold = 1'b0;
  end

  // ---------------- main sequence ----------------
  initial begin
    int nsent;
    int nbytes;
    p_open = 1'b0;
    clear_parse();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    push_noise(6);
    foreach (dir_rows[i])
      push_sentence(dir_rows[i].body, dir_rows[i].ck, dir_rows[i].term, dir_rows[i].pin,
                    dir_rows[i].cs, dir_rows[i].tv, dir_rows[i].pv);
    wait_drained();
    nsent = 0;
    nbytes = 0;
    while (nbytes < 1750 || nsent < 10) begin
      while (byte_q.size() >= 200) @(posedge clk_i);
      if ($urandom_range(0, 4) == 0) push_noise($urandom_range(1, 5));
      push_sentence(rand_body(), $urandom_range(0, 9) < 8 ? $urandom_range(CK_UPPER, CK_LOWER)
                    : ($urandom_range(0, 1) ? CK_BAD : CK_NONE),
                    rand_term(), 0, 0, 0, 0);
      nsent++;
      nbytes = taken + byte_q.size();
      quiet = (nsent >= 2 && nsent < 6);
      if (nsent == 7) wait_drained();
    end
    quiet = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && fix_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/nrmc_pkg.sv
src/nrmc_byte_if.sv
src/nrmc_res_if.sv
src/nmea_rmc_sentence_parser.sv
tb/tb_top.sv
